[rtl/core/cpc_pkg.sv]
// Shared constants and types for the circle clamp pipeline.
package cpc_pkg;

	localparam int FRAC_BITS    = 20;
	localparam int CENTER_BITS  = 11;
	localparam int RADIUS_BITS  = 8;
	localparam int KINV_BITS    = 30;
	localparam int KINV_SHIFT   = KINV_BITS - FRAC_BITS;
	localparam int CFG_IDX_BITS = 3;
	localparam int CFG_DATA_BITS = 11;

	// Inverse CORDIC gain, 30 fraction bits
	localparam logic [KINV_BITS-1:0] KINV_Q30 = 30'd652032874;

	// Configuration register indexes
	localparam logic [CFG_IDX_BITS-1:0] REG_FIRST_CX  = 3'd0;
	localparam logic [CFG_IDX_BITS-1:0] REG_FIRST_CY  = 3'd1;
	localparam logic [CFG_IDX_BITS-1:0] REG_SECOND_CX = 3'd2;
	localparam logic [CFG_IDX_BITS-1:0] REG_SECOND_CY = 3'd3;
	localparam logic [CFG_IDX_BITS-1:0] REG_RADIUS    = 3'd4;

	// Register reset values
	localparam logic [CENTER_BITS-1:0] RST_FIRST_CX  = 11'd330;
	localparam logic [CENTER_BITS-1:0] RST_FIRST_CY  = 11'd300;
	localparam logic [CENTER_BITS-1:0] RST_SECOND_CX = 11'd480;
	localparam logic [CENTER_BITS-1:0] RST_SECOND_CY = 11'd300;
	localparam logic [RADIUS_BITS-1:0] RST_RADIUS    = 8'd30;

	typedef struct packed {
		logic flip;
		logic in_circle;
	} ctl_t;

endpackage

[rtl/core/cpc_prep.sv]
// Offset from a center, inside test and left half plane fold ahead of the CORDIC row.
module cpc_prep #(
	parameter int COORD_BITS = 12,
	parameter int DW = 13,
	parameter int VW = 35
) (
	input  logic                                clk,
	input  logic                                en,
	input  logic signed [COORD_BITS-1:0]        px,
	input  logic signed [COORD_BITS-1:0]        py,
	input  logic [cpc_pkg::CENTER_BITS-1:0]     cx,
	input  logic [cpc_pkg::CENTER_BITS-1:0]     cy,
	input  logic [2*cpc_pkg::RADIUS_BITS-1:0]   rsq,
	output logic signed [VW-1:0]                x0,
	output logic signed [VW-1:0]                y0,
	output cpc_pkg::ctl_t                       ctl,
	output logic [cpc_pkg::CENTER_BITS-1:0]     cx_out,
	output logic [cpc_pkg::CENTER_BITS-1:0]     cy_out
);
	import cpc_pkg::*;

	localparam int SQW = 2 * DW;

	logic signed [DW-1:0] pxe, pye, cxe, cye;
	logic signed [DW-1:0] dx_s1, dy_s1;
	logic [CENTER_BITS-1:0] cx_s1, cy_s1;
	logic [SQW-1:0] sqx_s2, sqy_s2;
	logic signed [DW-1:0] ox_s2, oy_s2;
	logic flip_s2;
	logic [CENTER_BITS-1:0] cx_s2, cy_s2;
	logic [SQW:0] dist_sq;

	assign pxe = DW'(px);
	assign pye = DW'(py);
	assign cxe = DW'(cx);
	assign cye = DW'(cy);

	always_ff @(posedge clk) begin
		if (en) begin
			dx_s1 <= pxe - cxe;
			dy_s1 <= pye - cye;
			cx_s1 <= cx;
			cy_s1 <= cy;
			sqx_s2 <= SQW'(dx_s1 * dx_s1);
			sqy_s2 <= SQW'(dy_s1 * dy_s1);
			// fold the left half plane onto the right
			flip_s2 <= dx_s1[DW-1];
			ox_s2 <= dx_s1[DW-1] ? -dx_s1 : dx_s1;
			oy_s2 <= dx_s1[DW-1] ? -dy_s1 : dy_s1;
			cx_s2 <= cx_s1;
			cy_s2 <= cy_s1;
		end
	end

	assign dist_sq = (SQW+1)'(sqx_s2) + (SQW+1)'(sqy_s2);

	assign ctl.flip      = flip_s2;
	assign ctl.in_circle = dist_sq < (SQW+1)'(rsq);
	assign x0 = {(VW-FRAC_BITS)'(ox_s2), {FRAC_BITS{1'b0}}};
	assign y0 = {(VW-FRAC_BITS)'(oy_s2), {FRAC_BITS{1'b0}}};
	assign cx_out = cx_s2;
	assign cy_out = cy_s2;

endmodule

[rtl/core/cpc_cell.sv]
// One CORDIC step: vectoring on the offset steers rotation of the scaled radius.
module cpc_cell #(
	parameter int VW = 35,
	parameter int UW = 30,
	parameter int STEP = 0
) (
	input  logic                 clk,
	input  logic                 en,
	input  logic signed [VW-1:0] x_in,
	input  logic signed [VW-1:0] y_in,
	input  logic signed [UW-1:0] u_in,
	input  logic signed [UW-1:0] v_in,
	output logic signed [VW-1:0] x_out,
	output logic signed [VW-1:0] y_out,
	output logic signed [UW-1:0] u_out,
	output logic signed [UW-1:0] v_out
);
	logic signed [VW-1:0] xs, ys;
	logic signed [UW-1:0] us, vs;
	logic dir;
	logic signed [VW-1:0] x_q, y_q;
	logic signed [UW-1:0] u_q, v_q;

	assign xs = x_in >>> STEP;
	assign ys = y_in >>> STEP;
	assign us = u_in >>> STEP;
	assign vs = v_in >>> STEP;
	// rotate clockwise while the offset is on or above the axis
	assign dir = ~y_in[VW-1];

	always_ff @(posedge clk) begin
		if (en) begin
			if (dir) begin
				x_q <= x_in + ys;
				y_q <= y_in - xs;
				u_q <= u_in - vs;
				v_q <= v_in + us;
			end else begin
				x_q <= x_in - ys;
				y_q <= y_in + xs;
				u_q <= u_in + vs;
				v_q <= v_in - us;
			end
		end
	end

	assign x_out = x_q;
	assign y_out = y_q;
	assign u_out = u_q;
	assign v_out = v_q;

endmodule

[rtl/core/cpc_finish.sv]
// Unfold, round to a pixel, add the center and saturate; holds the result register.
module cpc_finish #(
	parameter int COORD_BITS = 12,
	parameter int UW = 30
) (
	input  logic                            clk,
	input  logic                            en,
	input  logic signed [UW-1:0]            u,
	input  logic signed [UW-1:0]            v,
	input  cpc_pkg::ctl_t                   ctl,
	input  logic [cpc_pkg::CENTER_BITS-1:0] cx,
	input  logic [cpc_pkg::CENTER_BITS-1:0] cy,
	input  logic signed [COORD_BITS-1:0]    px,
	input  logic signed [COORD_BITS-1:0]    py,
	output logic signed [COORD_BITS-1:0]    res_x,
	output logic signed [COORD_BITS-1:0]    res_y,
	output logic                            in_circle
);
	import cpc_pkg::*;

	localparam int RXW  = UW + 1 - FRAC_BITS;
	localparam int CW   = CENTER_BITS + 1;
	localparam int MW0  = (COORD_BITS > CW) ? COORD_BITS : CW;
	localparam int MW1  = (MW0 > RXW) ? MW0 : RXW;
	localparam int SUMW = MW1 + 1;
	localparam logic signed [UW:0] HALF = (UW+1)'(2 ** (FRAC_BITS - 1));
	localparam logic signed [SUMW-1:0] SAT_HI = SUMW'((2 ** (COORD_BITS - 1)) - 1);
	localparam logic signed [SUMW-1:0] SAT_LO = -SUMW'(2 ** (COORD_BITS - 1));

	logic signed [UW:0] ue, ve, ur, vr;
	logic signed [RXW-1:0] rx_f1, ry_f1;
	logic in_circle_f1;
	logic [CENTER_BITS-1:0] cx_f1, cy_f1;
	logic signed [COORD_BITS-1:0] px_f1, py_f1;
	logic signed [CW-1:0] cxs, cys;
	logic signed [SUMW-1:0] sum_x, sum_y;
	logic signed [COORD_BITS-1:0] res_x_q, res_y_q;
	logic in_circle_q;

	function automatic logic signed [COORD_BITS-1:0] sat(input logic signed [SUMW-1:0] s);
		logic signed [COORD_BITS-1:0] r;
		if (s > SAT_HI) begin
			r = SAT_HI[COORD_BITS-1:0];
		end else if (s < SAT_LO) begin
			r = SAT_LO[COORD_BITS-1:0];
		end else begin
			r = s[COORD_BITS-1:0];
		end
		return r;
	endfunction

	assign ue = (UW+1)'(u);
	assign ve = (UW+1)'(v);
	// undo the fold and add the rounding half in one adder
	assign ur = ctl.flip ? (HALF - ue) : (ue + HALF);
	assign vr = ctl.flip ? (HALF - ve) : (ve + HALF);

	always_ff @(posedge clk) begin
		if (en) begin
			rx_f1 <= ur[UW:FRAC_BITS];
			ry_f1 <= vr[UW:FRAC_BITS];
			in_circle_f1 <= ctl.in_circle;
			cx_f1 <= cx;
			cy_f1 <= cy;
			px_f1 <= px;
			py_f1 <= py;
		end
	end

	assign cxs = CW'(cx_f1);
	assign cys = CW'(cy_f1);
	assign sum_x = SUMW'(cxs) + SUMW'(rx_f1);
	assign sum_y = SUMW'(cys) + SUMW'(ry_f1);

	always_ff @(posedge clk) begin
		if (en) begin
			res_x_q <= in_circle_f1 ? px_f1 : sat(sum_x);
			res_y_q <= in_circle_f1 ? py_f1 : sat(sum_y);
			in_circle_q <= in_circle_f1;
		end
	end

	assign res_x = res_x_q;
	assign res_y = res_y_q;
	assign in_circle = in_circle_q;

endmodule

[rtl/core/clamp_point_to_circle.sv]
// Clamp a cursor point to a circle around each of two centers, one CORDIC row per center.
// From input transfer to result valid a point passes the prep, the row and the finish registers.
// Throughput: one point per cycle; each step of the row is a register stage.
// A stalled result holds the whole pipeline; the input stalls only then.
// Reset clears the valid pipeline and loads the default centers and radius.
module clamp_point_to_circle #(
	parameter int COORD_BITS = 12,
	parameter int CORDIC_STEPS = 16
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic signed [COORD_BITS-1:0]        cursor_x,
	input  logic signed [COORD_BITS-1:0]        cursor_y,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic signed [COORD_BITS-1:0]        first_result_x,
	output logic signed [COORD_BITS-1:0]        first_result_y,
	output logic                                first_inside,
	output logic signed [COORD_BITS-1:0]        second_result_x,
	output logic signed [COORD_BITS-1:0]        second_result_y,
	output logic                                second_inside,
	input  logic                                cfg_wen,
	input  logic [cpc_pkg::CFG_IDX_BITS-1:0]    cfg_idx,
	input  logic [cpc_pkg::CFG_DATA_BITS-1:0]   cfg_wdata
);
	import cpc_pkg::*;

	localparam int N   = CORDIC_STEPS;
	localparam int MW  = (COORD_BITS > 12) ? COORD_BITS : 12;
	localparam int DW  = MW + 1;
	localparam int VW  = DW + 2 + FRAC_BITS;
	localparam int UW  = RADIUS_BITS + 2 + FRAC_BITS;
	localparam int PW  = RADIUS_BITS + KINV_BITS;
	localparam int NV  = N + 3;

	logic adv;
	logic [NV-1:0] vld_q;
	logic out_valid_q;

	logic [CENTER_BITS-1:0] fcx_q, fcy_q, scx_q, scy_q;
	logic [RADIUS_BITS-1:0] radius_q;
	logic [CENTER_BITS-1:0] cen_x [2];
	logic [CENTER_BITS-1:0] cen_y [2];

	logic [RADIUS_BITS-1:0] r_s1;
	logic [PW-1:0] u0_prod;
	logic signed [UW-1:0] u0_s2;
	logic [2*RADIUS_BITS-1:0] rsq_s2;
	logic signed [COORD_BITS-1:0] px_s1, py_s1, px_s2, py_s2;

	logic signed [VW-1:0] x_ch [2][N];
	logic signed [VW-1:0] y_ch [2][N];
	logic signed [UW-1:0] u_ch [2][N+1];
	logic signed [UW-1:0] v_ch [2][N+1];
	ctl_t ctl_p [2];
	logic [CENTER_BITS-1:0] cxp [2];
	logic [CENTER_BITS-1:0] cyp [2];

	ctl_t ctl_sb [2][N];
	logic [CENTER_BITS-1:0] cx_sb [2][N];
	logic [CENTER_BITS-1:0] cy_sb [2][N];
	logic signed [COORD_BITS-1:0] px_sb [N];
	logic signed [COORD_BITS-1:0] py_sb [N];

	logic signed [COORD_BITS-1:0] res_x [2];
	logic signed [COORD_BITS-1:0] res_y [2];
	logic res_in [2];

	// advance whenever the result register is free or being taken
	assign adv = ~out_valid_q | ~out_stall;
	assign in_stall = ~adv;
	assign out_valid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fcx_q <= RST_FIRST_CX;
			fcy_q <= RST_FIRST_CY;
			scx_q <= RST_SECOND_CX;
			scy_q <= RST_SECOND_CY;
			radius_q <= RST_RADIUS;
		end else if (cfg_wen) begin
			unique case (cfg_idx)
				REG_FIRST_CX:  fcx_q <= cfg_wdata[CENTER_BITS-1:0];
				REG_FIRST_CY:  fcy_q <= cfg_wdata[CENTER_BITS-1:0];
				REG_SECOND_CX: scx_q <= cfg_wdata[CENTER_BITS-1:0];
				REG_SECOND_CY: scy_q <= cfg_wdata[CENTER_BITS-1:0];
				REG_RADIUS:    radius_q <= cfg_wdata[RADIUS_BITS-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		cen_x[0] = fcx_q;
		cen_y[0] = fcy_q;
		cen_x[1] = scx_q;
		cen_y[1] = scy_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
			out_valid_q <= 1'b0;
		end else if (adv) begin
			vld_q <= {vld_q[NV-2:0], in_valid};
			out_valid_q <= vld_q[NV-1];
		end
	end

	assign u0_prod = PW'(r_s1) * PW'(KINV_Q30);

	always_ff @(posedge clk) begin
		if (adv) begin
			r_s1 <= radius_q;
			u0_s2 <= UW'(u0_prod >> KINV_SHIFT);
			rsq_s2 <= (2*RADIUS_BITS)'(r_s1 * r_s1);
			px_s1 <= cursor_x;
			py_s1 <= cursor_y;
			px_s2 <= px_s1;
			py_s2 <= py_s1;
			px_sb[0] <= px_s2;
			py_sb[0] <= py_s2;
			for (int i = 1; i < N; i++) begin
				px_sb[i] <= px_sb[i-1];
				py_sb[i] <= py_sb[i-1];
			end
		end
	end

	for (genvar c = 0; c < 2; c++) begin : g_ctr
		cpc_prep #(
			.COORD_BITS(COORD_BITS),
			.DW(DW),
			.VW(VW)
		) u_prep (
			.clk    (clk),
			.en     (adv),
			.px     (cursor_x),
			.py     (cursor_y),
			.cx     (cen_x[c]),
			.cy     (cen_y[c]),
			.rsq    (rsq_s2),
			.x0     (x_ch[c][0]),
			.y0     (y_ch[c][0]),
			.ctl    (ctl_p[c]),
			.cx_out (cxp[c]),
			.cy_out (cyp[c])
		);

		assign u_ch[c][0] = u0_s2;
		assign v_ch[c][0] = '0;

		for (genvar i = 0; i < N; i++) begin : g_cell
			if (i < N - 1) begin : g_mid
				cpc_cell #(.VW(VW), .UW(UW), .STEP(i)) u_cell (
					.clk   (clk),
					.en    (adv),
					.x_in  (x_ch[c][i]),
					.y_in  (y_ch[c][i]),
					.u_in  (u_ch[c][i]),
					.v_in  (v_ch[c][i]),
					.x_out (x_ch[c][i+1]),
					.y_out (y_ch[c][i+1]),
					.u_out (u_ch[c][i+1]),
					.v_out (v_ch[c][i+1])
				);
			end else begin : g_last
				cpc_cell #(.VW(VW), .UW(UW), .STEP(i)) u_cell (
					.clk   (clk),
					.en    (adv),
					.x_in  (x_ch[c][i]),
					.y_in  (y_ch[c][i]),
					.u_in  (u_ch[c][i]),
					.v_in  (v_ch[c][i]),
					.x_out (),
					.y_out (),
					.u_out (u_ch[c][i+1]),
					.v_out (v_ch[c][i+1])
				);
			end
		end

		// side data rides along with the row
		always_ff @(posedge clk) begin
			if (adv) begin
				ctl_sb[c][0] <= ctl_p[c];
				cx_sb[c][0] <= cxp[c];
				cy_sb[c][0] <= cyp[c];
				for (int i = 1; i < N; i++) begin
					ctl_sb[c][i] <= ctl_sb[c][i-1];
					cx_sb[c][i] <= cx_sb[c][i-1];
					cy_sb[c][i] <= cy_sb[c][i-1];
				end
			end
		end

		cpc_finish #(
			.COORD_BITS(COORD_BITS),
			.UW(UW)
		) u_finish (
			.clk       (clk),
			.en        (adv),
			.u         (u_ch[c][N]),
			.v         (v_ch[c][N]),
			.ctl       (ctl_sb[c][N-1]),
			.cx        (cx_sb[c][N-1]),
			.cy        (cy_sb[c][N-1]),
			.px        (px_sb[N-1]),
			.py        (py_sb[N-1]),
			.res_x     (res_x[c]),
			.res_y     (res_y[c]),
			.in_circle (res_in[c])
		);
	end

	assign first_result_x  = res_x[0];
	assign first_result_y  = res_y[0];
	assign first_inside    = res_in[0];
	assign second_result_x = res_x[1];
	assign second_result_y = res_y[1];
	assign second_inside   = res_in[1];

endmodule
